// ===== rtl/core/alr_pkg.sv =====
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants
// Widths, codes and divider handshake structs for the line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int COORD_BITS = 13;             // output coordinate width
    localparam int IN_BITS    = 12;             // endpoint input width
    localparam int CFG_BITS   = 12;             // config register width
    localparam int CW         = IN_BITS + 2;    // internal coordinate width
    localparam int RW         = CW + 1;         // row width incl. minor carry
    localparam int FRAC       = 16;             // slope fraction bits
    localparam int SLOPE_W    = FRAC + 2;
    localparam int MP_W       = RW + FRAC;
    localparam int DVW        = CW - 1;         // divisor / remainder width
    localparam int QW         = FRAC + 1;       // max quotient bits
    localparam int CNT_W      = 5;
    localparam int CH_W       = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int NUM_W      = CH_W + DVW;

    localparam logic [CFG_BITS-1:0] CENTER_X_RST = 12'd960;
    localparam logic [CFG_BITS-1:0] CENTER_Y_RST = 12'd540;

    localparam logic CFG_CENTER_X = 1'b0;
    localparam logic CFG_CENTER_Y = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic             start;
        logic [DVW-1:0]   rem0;
        logic [QW-1:0]    low;
        logic [CNT_W-1:0] num;
        logic [DVW-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [QW-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/core/alr_if.sv =====
// ----------------------------------------------------------------------------
// alr_in_if / alr_out_if: valid/ready channels
// Input command word and output column word of the line rasterizer.
// ----------------------------------------------------------------------------
interface alr_in_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic signed [alr_pkg::IN_BITS-1:0] x_start;
    logic signed [alr_pkg::IN_BITS-1:0] y_start;
    logic signed [alr_pkg::IN_BITS-1:0] x_finish;
    logic signed [alr_pkg::IN_BITS-1:0] y_finish;
    logic [alr_pkg::RGB_W-1:0]          rgb_start;
    logic [alr_pkg::RGB_W-1:0]          rgb_finish;

    modport source (output valid, opcode, x_start, y_start, x_finish, y_finish,
                    rgb_start, rgb_finish, input ready);
    modport sink   (input valid, opcode, x_start, y_start, x_finish, y_finish,
                    rgb_start, rgb_finish, output ready);
endinterface

interface alr_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [alr_pkg::COORD_BITS-1:0] near_x;
    logic signed [alr_pkg::COORD_BITS-1:0] near_y;
    logic [alr_pkg::RGB_W-1:0]             near_rgb;
    logic signed [alr_pkg::COORD_BITS-1:0] far_x;
    logic signed [alr_pkg::COORD_BITS-1:0] far_y;
    logic [alr_pkg::RGB_W-1:0]             far_rgb;
    logic                                  last;

    modport source (output valid, near_x, near_y, near_rgb, far_x, far_y, far_rgb,
                    last, input ready);
    modport sink   (input valid, near_x, near_y, near_rgb, far_x, far_y, far_rgb,
                    last, output ready);
endinterface

// ===== rtl/core/alr_div.sv =====
// ----------------------------------------------------------------------------
// alr_div: shared restoring divider
// One quotient bit per cycle; remainder preloaded, low dividend bits MSB first.
// ----------------------------------------------------------------------------
module alr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alr_pkg::t_div_req i_req,
    output alr_pkg::t_div_rsp o_rsp
);
    logic [alr_pkg::DVW-1:0]   r_rem;
    logic [alr_pkg::DVW-1:0]   r_div;
    logic [alr_pkg::QW-1:0]    r_low;
    logic [alr_pkg::QW-1:0]    r_q;
    logic [alr_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [alr_pkg::DVW:0]     s_trial;
    logic [alr_pkg::DVW:0]     s_diff;
    logic                      s_ge;

    assign s_trial = {r_rem, r_low[alr_pkg::QW-1]};
    assign s_ge    = s_trial >= {1'b0, r_div};
    assign s_diff  = s_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.rem0;
                r_low  <= i_req.low;
                r_div  <= i_req.divisor;
                r_cnt  <= i_req.num;
                r_q    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= s_ge ? s_diff[alr_pkg::DVW-1:0] : s_trial[alr_pkg::DVW-1:0];
                r_low <= {r_low[alr_pkg::QW-2:0], 1'b0};
                r_q   <= {r_q[alr_pkg::QW-2:0], s_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == alr_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== rtl/core/antialiased_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: Wu antialiased line with colour gradient
// Sequencer around one shared restoring divider for slope and colour blend.
// ----------------------------------------------------------------------------
// One word is taken at a time; the input is not ready until the result word
// has been taken. A start word runs setup, the divider for the signed Q2.16
// slope, and the result (setup goes straight to the result for a span of
// zero). A step word for the second endpoint goes straight to its result. An
// interior column runs each of the three colour channels through a multiply
// state and the single divider in turn before the result, so that divider
// sets the rate. Steps while idle return nothing.

module antialiased_line_rasterizer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [alr_pkg::CFG_BITS-1:0] i_cfg_wdata,
    alr_in_if.sink                       i_in,
    alr_out_if.source                    o_out
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_SLOPE = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    localparam int CW    = alr_pkg::CW;
    localparam int RW    = alr_pkg::RW;
    localparam int FRAC  = alr_pkg::FRAC;
    localparam int DVW   = alr_pkg::DVW;
    localparam int CH_W  = alr_pkg::CH_W;
    localparam int NUM_W = alr_pkg::NUM_W;
    localparam int MP_W  = alr_pkg::MP_W;
    localparam int SW    = alr_pkg::SLOPE_W;
    localparam int QW    = alr_pkg::QW;

    t_state                  r_state;
    logic [alr_pkg::CFG_BITS-1:0] r_cx, r_cy;
    logic                    r_active, r_pend, r_steep;
    logic [CW-1:0]           r_col_first, r_col_final, r_col_now;
    logic [CW-1:0]           r_row_first, r_row_final;
    logic [SW-1:0]           r_slope;
    logic [MP_W-1:0]         r_mp;
    logic [alr_pkg::RGB_W-1:0] r_ca, r_cb;
    logic [1:0]              r_ch;
    logic [CH_W-1:0]         r_f8;
    logic [CW-1:0]           r_o_col;
    logic [RW-1:0]           r_o_row;
    logic [alr_pkg::RGB_W-1:0] r_near, r_far;
    logic                    r_last;

    alr_pkg::t_div_req       s_req;
    alr_pkg::t_div_rsp       s_rsp;

    // start-word geometry
    logic [CW-1:0] s_ax, s_ay, s_bx, s_by, s_dx, s_dy, s_adx, s_ady;
    logic [CW-1:0] s_pa, s_qa, s_pb, s_qb;
    logic          s_steep, s_swap, s_accept;

    // slope setup
    logic [CW-1:0] s_ddx, s_ddy, s_addy;
    logic [SW-1:0] s_qs, s_slope;

    // blend
    logic [CW-1:0]    s_kw, s_skw;
    logic [CH_W-1:0]  s_cha, s_chb, s_q;
    logic [NUM_W-1:0] s_num;
    logic [CH_W:0]    s_wn;
    logic [15:0]      s_pn, s_pf;
    logic [RW-1:0]    s_row_p1;
    logic             s_last2, s_lasti;

    assign s_accept = i_in.valid & i_in.ready;

    always_comb begin
        s_ax  = {{2{i_in.x_start[alr_pkg::IN_BITS-1]}}, i_in.x_start} + {2'b00, r_cx};
        s_ay  = {{2{i_in.y_start[alr_pkg::IN_BITS-1]}}, i_in.y_start} + {2'b00, r_cy};
        s_bx  = {{2{i_in.x_finish[alr_pkg::IN_BITS-1]}}, i_in.x_finish} + {2'b00, r_cx};
        s_by  = {{2{i_in.y_finish[alr_pkg::IN_BITS-1]}}, i_in.y_finish} + {2'b00, r_cy};
        s_dx  = s_bx - s_ax;
        s_dy  = s_by - s_ay;
        s_adx = s_dx[CW-1] ? -s_dx : s_dx;
        s_ady = s_dy[CW-1] ? -s_dy : s_dy;
        s_steep = s_ady > s_adx;
        s_pa  = s_steep ? s_ay : s_ax;
        s_qa  = s_steep ? s_ax : s_ay;
        s_pb  = s_steep ? s_by : s_bx;
        s_qb  = s_steep ? s_bx : s_by;
        s_swap = $signed(s_pa) > $signed(s_pb);
    end

    always_comb begin
        s_ddx  = r_col_final - r_col_first;
        s_ddy  = r_row_final - r_row_first;
        s_addy = s_ddy[CW-1] ? -s_ddy : s_ddy;
        s_qs   = {1'b0, s_rsp.quot};
        s_slope = s_ddy[CW-1] ? -s_qs : s_qs;
    end

    always_comb begin
        s_kw  = r_col_now - r_col_first;
        s_skw = r_col_final - r_col_now;
        s_cha = r_ca[{r_ch, 3'b000} +: CH_W];
        s_chb = r_cb[{r_ch, 3'b000} +: CH_W];
        s_num = NUM_W'(s_cha) * NUM_W'(s_skw[DVW-1:0])
              + NUM_W'(s_chb) * NUM_W'(s_kw[DVW-1:0]);
        s_q   = s_rsp.quot[CH_W-1:0];
        s_wn  = 9'd256 - {1'b0, r_f8};
        s_pn  = {8'd0, s_q} * {7'd0, s_wn};
        s_pf  = {8'd0, s_q} * {8'd0, r_f8};
        s_last2 = $signed({r_col_first[CW-1], r_col_first}) + RW'(1)
                  >= $signed({r_col_final[CW-1], r_col_final});
        s_lasti = $signed({r_col_now[CW-1], r_col_now}) + RW'(1)
                  >= $signed({r_col_final[CW-1], r_col_final});
    end

    // divider request: slope in setup, one channel per multiply cycle
    always_comb begin
        s_req = '0;
        if (r_state == ST_PREP) begin
            s_req.start   = (s_ddx != '0);
            s_req.rem0    = {1'b0, s_addy[DVW-1:1]};
            s_req.low     = {s_addy[0], {FRAC{1'b0}}};
            s_req.num     = alr_pkg::CNT_W'(QW);
            s_req.divisor = s_ddx[DVW-1:0];
        end else if (r_state == ST_MUL) begin
            s_req.start   = 1'b1;
            s_req.rem0    = s_num[NUM_W-1:CH_W];
            s_req.low     = {s_num[CH_W-1:0], {(QW-CH_W){1'b0}}};
            s_req.num     = alr_pkg::CNT_W'(CH_W);
            s_req.divisor = s_ddx[DVW-1:0];
        end
    end

    alr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .o_rsp   (s_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cx     <= alr_pkg::CENTER_X_RST;
            r_cy     <= alr_pkg::CENTER_Y_RST;
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_steep  <= 1'b0;
            r_ch     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    alr_pkg::CFG_CENTER_X: r_cx <= i_cfg_wdata;
                    alr_pkg::CFG_CENTER_Y: r_cy <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_accept && i_in.opcode == alr_pkg::OP_START) begin
                        r_steep     <= s_steep;
                        r_col_first <= s_swap ? s_pb : s_pa;
                        r_row_first <= s_swap ? s_qb : s_qa;
                        r_col_final <= s_swap ? s_pa : s_pb;
                        r_row_final <= s_swap ? s_qa : s_qb;
                        r_ca        <= s_swap ? i_in.rgb_finish : i_in.rgb_start;
                        r_cb        <= s_swap ? i_in.rgb_start : i_in.rgb_finish;
                        r_col_now   <= (s_swap ? s_pb : s_pa) + CW'(1);
                        r_active    <= 1'b1;
                        r_pend      <= 1'b1;
                        r_state     <= ST_PREP;
                    end else if (s_accept && r_active && r_pend) begin
                        r_pend  <= 1'b0;
                        r_active <= ~s_last2;
                        r_o_col <= r_col_final;
                        r_o_row <= {r_row_final[CW-1], r_row_final};
                        r_near  <= {1'b0, r_cb[23:17], 1'b0, r_cb[15:9], 1'b0, r_cb[7:1]};
                        r_far   <= '0;
                        r_last  <= s_last2;
                        r_state <= ST_OUT;
                    end else if (s_accept && r_active) begin
                        r_o_col <= r_col_now;
                        r_o_row <= r_mp[MP_W-1:FRAC];
                        r_f8    <= r_mp[FRAC-1:FRAC-CH_W];
                        r_last  <= s_lasti;
                        r_ch    <= 2'd2;
                        r_state <= ST_MUL;
                    end
                end
                ST_PREP: begin
                    r_o_col <= r_col_first;
                    r_o_row <= {r_row_first[CW-1], r_row_first};
                    r_near  <= {1'b0, r_ca[23:17], 1'b0, r_ca[15:9], 1'b0, r_ca[7:1]};
                    r_far   <= '0;
                    r_last  <= 1'b0;
                    if (s_ddx == '0) begin
                        // degenerate line: slope is exactly one
                        r_slope <= SW'(1) << FRAC;
                        r_mp    <= {r_row_first[CW-1], r_row_first, {FRAC{1'b0}}}
                                 + (MP_W'(1) << FRAC);
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_SLOPE;
                    end
                end
                ST_SLOPE: begin
                    if (s_rsp.done) begin
                        r_slope <= s_slope;
                        r_mp    <= {r_row_first[CW-1], r_row_first, {FRAC{1'b0}}}
                                 + {{(MP_W-SW){s_slope[SW-1]}}, s_slope};
                        r_state <= ST_OUT;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (s_rsp.done) begin
                        r_near[{r_ch, 3'b000} +: CH_W] <= s_pn[15:8];
                        r_far[{r_ch, 3'b000} +: CH_W]  <= s_pf[15:8];
                        if (r_ch == 2'd0) begin
                            r_mp      <= r_mp + {{(MP_W-SW){r_slope[SW-1]}}, r_slope};
                            r_col_now <= r_col_now + CW'(1);
                            if (r_last) begin
                                r_active <= 1'b0;
                            end
                            r_state <= ST_OUT;
                        end else begin
                            r_ch    <= r_ch - 2'd1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_row_p1 = r_o_row + RW'(1);

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = (r_state == ST_OUT);
    assign o_out.near_x   = r_steep ? r_o_row[alr_pkg::COORD_BITS-1:0]
                                    : r_o_col[alr_pkg::COORD_BITS-1:0];
    assign o_out.near_y   = r_steep ? r_o_col[alr_pkg::COORD_BITS-1:0]
                                    : r_o_row[alr_pkg::COORD_BITS-1:0];
    assign o_out.far_x    = r_steep ? s_row_p1[alr_pkg::COORD_BITS-1:0]
                                    : r_o_col[alr_pkg::COORD_BITS-1:0];
    assign o_out.far_y    = r_steep ? r_o_col[alr_pkg::COORD_BITS-1:0]
                                    : s_row_p1[alr_pkg::COORD_BITS-1:0];
    assign o_out.near_rgb = r_near;
    assign o_out.far_rgb  = r_far;
    assign o_out.last     = r_last;

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_rsp.done |-> (r_state == ST_SLOPE || r_state == ST_DIV))
        else $error("divider finished outside a waiting state");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_req.start |-> !s_rsp.busy)
        else $error("divider restarted while busy");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_in.opcode == alr_pkg::OP_START) |=> (r_active && r_pend))
        else $error("start word did not arm the line");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch != 2'd3)
        else $error("channel counter out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |-> !r_active)
        else $error("last column left the line active");

endmodule

// ===== tb/antialiased_line_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_tb: self-checking bench for the line rasterizer
// Directed and random line commands go in through a queued driver. Every column
// word that comes out is checked against a behavioral model of the Wu stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module antialiased_line_rasterizer_tb;
    localparam int IN_BITS    = alr_pkg::IN_BITS;
    localparam int RGB_W      = alr_pkg::RGB_W;
    localparam int COORD_BITS = alr_pkg::COORD_BITS;
    localparam int CFG_BITS   = alr_pkg::CFG_BITS;
    localparam int FRAC       = alr_pkg::FRAC;

    typedef struct {
        logic              opcode;
        logic [IN_BITS-1:0] xs, ys, xf, yf;
        logic [RGB_W-1:0]  cs, cf;
    } t_cmd;

    typedef struct {
        logic [COORD_BITS-1:0] nx, ny, fx, fy;
        logic [RGB_W-1:0]      nrgb, frgb;
        logic                  last;
    } t_col;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = alr_pkg::CFG_CENTER_X;
    logic [CFG_BITS-1:0] i_cfg_wdata = '0;

    alr_in_if  in_ch ();
    alr_out_if out_ch ();

    antialiased_line_rasterizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // model state
    longint cx, cy, col_now, col_first, col_final, row_final, slope_q, minor_q;
    bit     active_q, steep_q, second_q;
    logic [RGB_W-1:0] rgb_first, rgb_final;

    t_cmd cmd_q[$];
    t_col col_expect_q[$];
    int   errors = 0;
    bit   hold_rx = 1'b0;

    function automatic logic [RGB_W-1:0] shade(logic [RGB_W-1:0] c, int w);
        logic [RGB_W-1:0] r;
        int ch;
        r = '0;
        for (int s = 0; s < 3; s++) begin
            ch = (int'(c[s*8 +: 8]) * w) >> 8;
            if (ch > 255) ch = 255;
            r[s*8 +: 8] = ch[7:0];
        end
        return r;
    endfunction

    function automatic logic [RGB_W-1:0] mix(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b,
                                             longint k, longint span);
        logic [RGB_W-1:0] r;
        longint ch;
        if (span == 0) return a;
        r = '0;
        for (int s = 0; s < 3; s++) begin
            ch = (longint'(a[s*8 +: 8]) * (span - k) + longint'(b[s*8 +: 8]) * k) / span;
            if (ch > 255) ch = 255;
            r[s*8 +: 8] = ch[7:0];
        end
        return r;
    endfunction

    function automatic t_col make_col(longint c, longint r, logic [RGB_W-1:0] rgb,
                                      int wn, int wf, bit lst);
        t_col o;
        o.nx = COORD_BITS'(steep_q ? r : c);
        o.ny = COORD_BITS'(steep_q ? c : r);
        o.fx = COORD_BITS'(steep_q ? r + 1 : c);
        o.fy = COORD_BITS'(steep_q ? c : r + 1);
        o.nrgb = shade(rgb, wn);
        o.frgb = shade(rgb, wf);
        o.last = lst;
        return o;
    endfunction

    task automatic predict_column(t_cmd w);
        longint one, ax, ay, bx, by, dx, dy, t, ip, fr;
        logic [RGB_W-1:0] ca, cb, tc;
        bit lst;
        one = longint'(1) << FRAC;
        if (w.opcode == alr_pkg::OP_START) begin
            ax = longint'($signed(w.xs)) + cx; ay = longint'($signed(w.ys)) + cy;
            bx = longint'($signed(w.xf)) + cx; by = longint'($signed(w.yf)) + cy;
            ca = w.cs; cb = w.cf;
            dx = bx - ax; dy = by - ay;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            steep_q = dy > dx;
            if (steep_q) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
                tc = ca; ca = cb; cb = tc;
            end
            dx = bx - ax; dy = by - ay;
            slope_q = (dx == 0) ? one : (dy * one) / dx;
            col_first = ax; col_final = bx; row_final = by;
            rgb_first = ca; rgb_final = cb;
            minor_q = ay * one + slope_q;
            col_now = ax + 1;
            second_q = 1; active_q = 1;
            col_expect_q.push_back(make_col(ax, ay, ca, 128, 0, 0));
        end else if (active_q) begin
            if (second_q) begin
                lst = col_first + 1 >= col_final;
                second_q = 0;
                if (lst) active_q = 0;
                col_expect_q.push_back(make_col(col_final, row_final, rgb_final, 128, 0, lst));
            end else begin
                if (minor_q >= 0) ip = minor_q / one;
                else ip = -((-minor_q + one - 1) / one);
                fr = (minor_q - ip * one) >> (FRAC - 8);
                lst = col_now + 1 >= col_final;
                col_expect_q.push_back(make_col(col_now, ip,
                    mix(rgb_first, rgb_final, col_now - col_first, col_final - col_first),
                    256 - int'(fr & 255), int'(fr & 255), lst));
                minor_q += slope_q;
                col_now += 1;
                if (lst) active_q = 0;
            end
        end
    endtask

    // driver
    int tx_gap = 0;
    initial begin
        in_ch.valid = 1'b0; in_ch.opcode = alr_pkg::OP_STEP;
        in_ch.x_start = '0; in_ch.y_start = '0; in_ch.x_finish = '0; in_ch.y_finish = '0;
        in_ch.rgb_start = '0; in_ch.rgb_finish = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        t_cmd w;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                w.opcode = in_ch.opcode;
                w.xs = in_ch.x_start; w.ys = in_ch.y_start;
                w.xf = in_ch.x_finish; w.yf = in_ch.y_finish;
                w.cs = in_ch.rgb_start; w.cf = in_ch.rgb_finish;
                predict_column(w);
                void'(cmd_q.pop_front());
                tx_gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold word
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end else if (cmd_q.size() > 0 && !(in_ch.valid && in_ch.ready && cmd_q.size() == 0)) begin
                in_ch.valid      <= 1'b1;
                in_ch.opcode     <= cmd_q[0].opcode;
                in_ch.x_start    <= cmd_q[0].xs;
                in_ch.y_start    <= cmd_q[0].ys;
                in_ch.x_finish   <= cmd_q[0].xf;
                in_ch.y_finish   <= cmd_q[0].yf;
                in_ch.rgb_start  <= cmd_q[0].cs;
                in_ch.rgb_finish <= cmd_q[0].cf;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge i_clk) begin
        t_col e;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (col_expect_q.size() == 0) begin
                    $error("unexpected word near_x=%0d", out_ch.near_x);
                    errors++;
                end else begin
                    e = col_expect_q.pop_front();
                    if (out_ch.near_x !== e.nx) begin
                        $error("near_x exp %0h got %0h", e.nx, out_ch.near_x); errors++;
                    end
                    if (out_ch.near_y !== e.ny) begin
                        $error("near_y exp %0h got %0h", e.ny, out_ch.near_y); errors++;
                    end
                    if (out_ch.near_rgb !== e.nrgb) begin
                        $error("near_rgb exp %0h got %0h", e.nrgb, out_ch.near_rgb); errors++;
                    end
                    if (out_ch.far_x !== e.fx) begin
                        $error("far_x exp %0h got %0h", e.fx, out_ch.far_x); errors++;
                    end
                    if (out_ch.far_y !== e.fy) begin
                        $error("far_y exp %0h got %0h", e.fy, out_ch.far_y); errors++;
                    end
                    if (out_ch.far_rgb !== e.frgb) begin
                        $error("far_rgb exp %0h got %0h", e.frgb, out_ch.far_rgb); errors++;
                    end
                    if (out_ch.last !== e.last) begin
                        $error("last exp %0b got %0b", e.last, out_ch.last); errors++;
                    end
                end
                rx_gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (hold_rx) begin
                out_ch.ready <= 1'b0;
            end else if (out_ch.valid && out_ch.ready) begin
                out_ch.ready <= (rx_gap == 0);
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 5000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_cmd rand_line(int lim);
        t_cmd w;
        w.opcode = alr_pkg::OP_START;
        w.xs = IN_BITS'($urandom_range(0, 2*lim) - lim);
        w.ys = IN_BITS'($urandom_range(0, 2*lim) - lim);
        w.xf = IN_BITS'($urandom_range(0, 2*lim) - lim);
        w.yf = IN_BITS'($urandom_range(0, 2*lim) - lim);
        w.cs = RGB_W'($urandom); w.cf = RGB_W'($urandom);
        return w;
    endfunction

    function automatic t_cmd step_cmd();
        t_cmd w;
        w = rand_line(2047);
        w.opcode = alr_pkg::OP_STEP;
        return w;
    endfunction

    function automatic t_cmd line_of(int xs, int ys, int xf, int yf,
                                     logic [RGB_W-1:0] cs, logic [RGB_W-1:0] cf);
        t_cmd w;
        w.opcode = alr_pkg::OP_START;
        w.xs = IN_BITS'(xs); w.ys = IN_BITS'(ys);
        w.xf = IN_BITS'(xf); w.yf = IN_BITS'(yf);
        w.cs = cs; w.cf = cf;
        return w;
    endfunction

    task automatic push_steps(int n);
        for (int i = 0; i < n; i++) cmd_q.push_back(step_cmd());
    endtask

    task automatic drain_all();
        wait (cmd_q.size() == 0);
        @(posedge i_clk);
        while (in_ch.valid || col_expect_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_center(logic idx, logic [CFG_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cx = (idx == alr_pkg::CFG_CENTER_X) ? longint'(v) : cx;
        cy = (idx == alr_pkg::CFG_CENTER_Y) ? longint'(v) : cy;
    endtask

    initial begin
        int n, span;
        bit held;
        cx = 960; cy = 540;
        active_q = 0; steep_q = 0; second_q = 0;
        held = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle step, shallow, steep, dot, span one, restart
        push_steps(1);
        cmd_q.push_back(line_of(-5, -3, 6, 2, 24'hFFFFFF, 24'h000000)); push_steps(12);
        cmd_q.push_back(line_of(3, 7, -1, -2, 24'h123456, 24'hFEDCBA)); push_steps(10);
        cmd_q.push_back(line_of(0, 0, 0, 0, 24'hABCDEF, 24'h010203)); push_steps(2);
        cmd_q.push_back(line_of(0, 0, 1, 1, 24'h808080, 24'h7F7F7F)); push_steps(2);
        cmd_q.push_back(line_of(2047, -2048, -2048, 2047, 24'hFFFFFF, 24'hFFFFFF));
        push_steps(3);
        cmd_q.push_back(line_of(-2048, 2047, 2047, -2048, 24'h000000, 24'hFFFFFF));
        push_steps(2);
        drain_all();

        // extremes of the offsets; out-of-range wrap and negative floors
        write_center(alr_pkg::CFG_CENTER_X, 12'd0);
        write_center(alr_pkg::CFG_CENTER_Y, 12'd0);
        cmd_q.push_back(line_of(-4, -9, 4, -1, 24'hF0F0F0, 24'h0F0F0F)); push_steps(10);
        cmd_q.push_back(line_of(2047, 2047, 2040, 2043, 24'hFFFFFF, 24'h00FF00));
        push_steps(9);
        drain_all();
        write_center(alr_pkg::CFG_CENTER_X, 12'd4095);
        write_center(alr_pkg::CFG_CENTER_Y, 12'd4095);
        cmd_q.push_back(line_of(2047, 2040, 2041, 2047, 24'h00FFFF, 24'hFF0000));
        push_steps(9);
        drain_all();
        write_center(alr_pkg::CFG_CENTER_X, 12'd2048);
        write_center(alr_pkg::CFG_CENTER_Y, 12'd2048);

        // random: mostly complete short lines, some cut off by a new start
        n = 0;
        for (int ph = 0; ph < 3; ph++) begin
            while (n < 130 * (ph + 1)) begin
                cmd_q.push_back(rand_line(($urandom % 8 == 0) ? 2047 : 12));
                span = $urandom_range(0, 14);
                if ($urandom % 6 == 0) span = $urandom_range(0, 3);
                push_steps(span);
                n += span + 1;
                if (ph == 1 && n > 200 && !held) begin
                    held = 1;
                    hold_rx = 1'b1;
                    repeat (300) @(posedge i_clk);
                    hold_rx = 1'b0;
                end
                wait (cmd_q.size() < 20);
            end
            drain_all();
            if (ph == 0) write_center(alr_pkg::CFG_CENTER_X, CFG_BITS'($urandom_range(0, 4095)));
            if (ph == 1) write_center(alr_pkg::CFG_CENTER_Y, CFG_BITS'($urandom_range(0, 4095)));
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
